>>> hdl/sbip_pkg.sv
// Shared types and constants for the shuffle-bag index picker.
package sbip_pkg;

    localparam int RND_W      = 16;
    localparam int STEP_W     = $clog2(RND_W);
    localparam int CNT_CFG_W  = 7;
    localparam int PICK_OUT_W = 6;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic capture;
        logic set_err;
        logic refill_init;
        logic refill_step;
        logic refill_end;
        logic mod_start;
        logic rd_pos;
        logic pick;
        logic shift_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic count_zero;
        logic refill_last;
        logic mod_done;
        logic shift_done;
    } t_sts;

endpackage

>>> hdl/sbip_mod.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
module sbip_mod #(
    parameter int CW = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sbip_pkg::RND_W-1:0] i_dividend,
    input  logic [CW-1:0]              i_divisor,
    output logic                       o_done,
    output logic [CW-1:0]              o_rem
);
    import sbip_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [RND_W-1:0]  r_dv;
    logic [CW-1:0]     r_div;
    logic [CW-1:0]     r_rem;
    logic [CW:0]       w_t;
    logic [CW-1:0]     n_rem;

    always_comb begin
        w_t = {r_rem, r_dv[RND_W-1]};
        if (w_t >= {1'b0, r_div}) begin
            n_rem = CW'(w_t - {1'b0, r_div});
        end else begin
            n_rem = CW'(w_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_dv   <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_dv   <= r_dv << 1;
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(RND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");

endmodule

>>> hdl/sbip_dp.sv
// Datapath: index list memory, count and hold registers, remainder unit.
module sbip_dp #(
    parameter int LIST_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [sbip_pkg::CNT_CFG_W-1:0]  i_entry_count,
    input  logic [sbip_pkg::RND_W-1:0]      i_random_value,
    input  sbip_pkg::t_cmd                  i_cmd,
    output sbip_pkg::t_sts                  o_sts,
    output logic [sbip_pkg::PICK_OUT_W-1:0] o_picked_index,
    output logic                            o_empty_error
);
    import sbip_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int IW = AW;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [IW-1:0]    r_mem [LIST_DEPTH];
    logic [IW-1:0]    r_rdata;
    logic [RND_W-1:0] r_rnd;
    logic [CW-1:0]    r_count;
    logic             r_hold;
    logic [IW-1:0]    r_held;
    logic [CW-1:0]    r_fill;
    logic [CW-1:0]    r_src;
    logic [CW-1:0]    r_dst;
    logic             r_pend;
    logic [IW-1:0]    r_picked;
    logic             r_err;

    logic [CW-1:0] w_n;
    logic [CW-1:0] w_rem;
    logic          w_mod_done;
    logic [CW-1:0] w_new_cnt;
    logic          w_skip;
    logic          w_rd_more;
    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [IW-1:0] w_wd;
    logic          w_re;
    logic [AW-1:0] w_ra;

    sbip_mod #(.CW(CW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_count),
        .o_done     (w_mod_done),
        .o_rem      (w_rem)
    );

    always_comb begin
        if (int'(i_entry_count) > LIST_DEPTH) begin
            w_n = CW'(LIST_DEPTH);
        end else begin
            w_n = CW'(i_entry_count);
        end
    end

    assign w_new_cnt = r_count - 1'b1;
    assign w_skip    = r_hold && (r_held == r_fill[IW-1:0]);
    assign w_rd_more = r_src < r_count;

    always_comb begin
        w_we = 1'b0;
        w_wa = '0;
        w_wd = '0;
        w_re = 1'b0;
        w_ra = '0;
        if (i_cmd.refill_step) begin
            w_we = !w_skip;
            w_wa = r_count[AW-1:0];
            w_wd = r_fill[IW-1:0];
        end else if (i_cmd.refill_end) begin
            w_we = (r_count == '0);
            w_wa = '0;
            w_wd = r_held;
        end else if (i_cmd.shift_step) begin
            w_we = r_pend;
            w_wa = r_dst[AW-1:0];
            w_wd = r_rdata;
        end else if (i_cmd.finish) begin
            w_we = r_hold && (int'(w_new_cnt) < LIST_DEPTH);
            w_wa = w_new_cnt[AW-1:0];
            w_wd = r_held;
        end
        if (i_cmd.rd_pos) begin
            w_re = 1'b1;
            w_ra = w_rem[AW-1:0];
        end else if (i_cmd.shift_step) begin
            w_re = w_rd_more;
            w_ra = r_src[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hold  <= 1'b0;
            r_held  <= '0;
            r_pend  <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_rnd <= i_random_value;
            end
            if (i_cmd.set_err) begin
                r_err    <= 1'b1;
                r_picked <= '0;
            end
            if (i_cmd.refill_init) begin
                r_fill  <= '0;
                r_count <= '0;
            end
            if (i_cmd.refill_step) begin
                r_fill <= r_fill + 1'b1;
                if (!w_skip) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.refill_end && (r_count == '0)) begin
                r_hold  <= 1'b0;
                r_count <= CW'(1);
            end
            if (i_cmd.pick) begin
                r_picked <= r_rdata;
                r_src    <= CW'(w_rem + 1'b1);
                r_dst    <= w_rem;
                r_pend   <= 1'b0;
            end
            if (i_cmd.shift_step) begin
                r_pend <= w_rd_more;
                if (w_rd_more) begin
                    r_src <= r_src + 1'b1;
                end
                if (r_pend) begin
                    r_dst <= r_dst + 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_err  <= 1'b0;
                r_hold <= 1'b0;
                if ((w_new_cnt == '0) && (w_n > CW'(1))) begin
                    r_hold <= 1'b1;
                    r_held <= r_picked;
                end
                if (r_hold && (int'(w_new_cnt) < LIST_DEPTH)) begin
                    r_count <= r_count;
                end else begin
                    r_count <= w_new_cnt;
                end
            end
        end
    end

    assign o_sts.n_zero      = (w_n == '0);
    assign o_sts.count_zero  = (r_count == '0);
    assign o_sts.refill_last = (r_fill == CW'(w_n - 1'b1));
    assign o_sts.mod_done    = w_mod_done;
    assign o_sts.shift_done  = !r_pend && !w_rd_more;

    assign o_picked_index = PICK_OUT_W'(r_picked);
    assign o_empty_error  = r_err;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= LIST_DEPTH)
        else $error("remaining count above list depth");

    a_shift_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_src == CW'(r_dst + 2'd2)))
        else $error("shift read and write pointers out of step");

endmodule

>>> hdl/sbip_ctrl.sv
// Controller: sequences refill, position, pick, shift and release per request.
module sbip_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  sbip_pkg::t_sts i_sts,
    output sbip_pkg::t_cmd o_cmd,
    output logic           o_strobe
);
    import sbip_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REFILL,
        S_REFILL_END,
        S_MOD_START,
        S_MOD_WAIT,
        S_READ,
        S_PICK,
        S_SHIFT,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_strobe;
    logic   w_accept;

    assign w_accept = start && (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_sts.n_zero) begin
                        o_cmd.set_err = 1'b1;
                    end else if (i_sts.count_zero) begin
                        o_cmd.refill_init = 1'b1;
                        n_state = S_REFILL;
                    end else begin
                        n_state = S_MOD_START;
                    end
                end
            end
            S_REFILL: begin
                o_cmd.refill_step = 1'b1;
                if (i_sts.refill_last) begin
                    n_state = S_REFILL_END;
                end
            end
            S_REFILL_END: begin
                o_cmd.refill_end = 1'b1;
                n_state = S_MOD_START;
            end
            S_MOD_START: begin
                o_cmd.mod_start = 1'b1;
                n_state = S_MOD_WAIT;
            end
            S_MOD_WAIT: begin
                if (i_sts.mod_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_pos = 1'b1;
                n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (w_accept && i_sts.n_zero) || (r_state == S_FINISH);
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_sts.n_zero) |=> (o_strobe && (r_state == S_IDLE)))
        else $error("empty-bag request gave no immediate beat");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state == S_FINISH) || $past(w_accept && i_sts.n_zero)))
        else $error("result beat without a finished request");

endmodule

>>> hdl/shuffle_bag_index_picker.sv
// Top level of the shuffle-bag index picker: APB register, controller, datapath.
//
//  channel   signals                                 direction  handshake
//  request   start, busy, i_random_value             in         start & !busy
//  result    o_strobe, o_picked_index, o_empty_error out        o_strobe, one cycle
//  config    psel, penable, pwrite, paddr, pwdata    in         APB, pready tied high
//
// A pick keeps busy high while it starts and waits on the bit-serial remainder,
// reads its position, takes the entry and moves the later entries down by the
// order-keeping shift (remaining - pos - 1 of them). The beat comes as busy drops.
// A request that finds the list empty first refills it, one entry per cycle.
// entry_count zero answers in the next cycle without raising busy.
// Reset is synchronous and clears the count and hold state; no clearing pass.
// Results are never stalled; busy holds off the next request.
module shuffle_bag_index_picker #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [sbip_pkg::RND_W-1:0]      i_random_value,
    output logic                            o_strobe,
    output logic [sbip_pkg::PICK_OUT_W-1:0] o_picked_index,
    output logic                            o_empty_error,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sbip_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sbip_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sbip_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import sbip_pkg::*;

    localparam int LIST_DEPTH = (MAX_ENTRIES < 127) ? MAX_ENTRIES : 127;

    logic [CNT_CFG_W-1:0] r_entry_count;
    t_cmd                 w_cmd;
    t_sts                 w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT)) begin
            r_entry_count <= pwdata[CNT_CFG_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_ENTRY_COUNT) begin
            prdata = APB_DATA_W'(r_entry_count);
        end else begin
            prdata = '0;
        end
    end

    assign pready = 1'b1;

    sbip_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_strobe (o_strobe)
    );

    sbip_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry_count  (r_entry_count),
        .i_random_value (i_random_value),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_picked_index (o_picked_index),
        .o_empty_error  (o_empty_error)
    );

endmodule

>>> tb/sv/shuffle_bag_index_picker_tb.sv
// Self-checking testbench for the shuffle-bag index picker against a predictor.
module shuffle_bag_index_picker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbip_pkg::*;

    localparam int BAG_MAX     = 64;
    localparam int PICK_TARGET = 950;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 200;
    localparam logic [APB_ADDR_W-1:0] ENTRY_COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

    typedef enum logic [1:0] {
        OP_PICK,
        OP_WRITE,
        OP_DRAIN
    } t_op;

    typedef struct {
        t_op         op;
        logic [31:0] value;
        int          gap;
        bit          after_busy;
    } t_bag_cmd;

    typedef struct packed {
        logic [PICK_OUT_W-1:0] idx;
        logic                  err;
    } t_pick;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [RND_W-1:0]      i_random_value = '0;
    logic                  o_strobe;
    logic [PICK_OUT_W-1:0] o_picked_index;
    logic                  o_empty_error;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state
    logic [PICK_OUT_W-1:0] bag_list [BAG_MAX];
    int                    bag_left = 0;
    logic                  hold_valid = 1'b0;
    logic [PICK_OUT_W-1:0] hold_idx = '0;
    logic [CNT_CFG_W-1:0]  bag_cfg = '0;

    t_bag_cmd cmd_q[$];
    t_pick    picks_due[$];
    int       mismatches = 0;
    int       results_seen = 0;
    int       quiet_cycles = 0;
    int       gap_left = 0;
    bit       armed = 1'b0;
    bit       calm = 1'b0;
    int       picks_queued = 0;

    shuffle_bag_index_picker #(
        .MAX_ENTRIES(BAG_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_random_value(i_random_value),
        .o_strobe      (o_strobe),
        .o_picked_index(o_picked_index),
        .o_empty_error (o_empty_error),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_pick serve_pick(input logic [RND_W-1:0] rnd);
        int                    n;
        int                    pos;
        t_pick                 res;
        logic [PICK_OUT_W-1:0] picked;
        logic                  rel;
        logic [PICK_OUT_W-1:0] rel_idx;
        n = (int'(bag_cfg) > BAG_MAX) ? BAG_MAX : int'(bag_cfg);
        res.idx = '0;
        res.err = 1'b1;
        if (n == 0) return res;
        if (bag_left == 0) begin
            for (int i = 0; i < n; i++) begin
                if (!(hold_valid && int'(hold_idx) == i)) begin
                    bag_list[bag_left] = PICK_OUT_W'(i);
                    bag_left++;
                end
            end
            // only index left is the held one: drop the hold and serve it
            if (bag_left == 0) begin
                hold_valid  = 1'b0;
                bag_list[0] = hold_idx;
                bag_left    = 1;
            end
        end
        pos    = int'(rnd) % bag_left;
        picked = bag_list[pos];
        for (int i = pos; i + 1 < bag_left; i++) bag_list[i] = bag_list[i + 1];
        bag_left--;
        rel        = hold_valid;
        rel_idx    = hold_idx;
        hold_valid = 1'b0;
        if (bag_left == 0 && n > 1) begin
            hold_valid = 1'b1;
            hold_idx   = picked;
        end
        if (rel && bag_left < BAG_MAX) begin
            bag_list[bag_left] = rel_idx;
            bag_left++;
        end
        res.idx = picked;
        res.err = 1'b0;
        return res;
    endfunction

    task automatic log_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s at beat %0d: got %0d want %0d",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    task automatic add_pick(input logic [RND_W-1:0] rnd);
        t_bag_cmd c;
        c.op         = OP_PICK;
        c.value      = 32'(rnd);
        c.gap        = calm ? 0 : int'($urandom_range(0, 11));
        c.after_busy = 1'($urandom_range(0, 1));
        cmd_q        = {cmd_q, c};
        picks_queued++;
    endtask

    task automatic add_write(input int cnt);
        t_bag_cmd c;
        c.op         = OP_WRITE;
        c.value      = 32'(cnt);
        c.gap        = 0;
        c.after_busy = 1'b0;
        cmd_q        = {cmd_q, c};
    endtask

    task automatic add_drain();
        t_bag_cmd c;
        c.op         = OP_DRAIN;
        c.value      = '0;
        c.gap        = 0;
        c.after_busy = 1'b0;
        cmd_q        = {cmd_q, c};
    endtask

    always @(posedge i_clk) begin : drive_p
        logic     nxt_start;
        logic     nxt_psel;
        logic     nxt_penable;
        logic     idle;
        t_bag_cmd head;
        if (!i_rst_n) begin
            start   <= 1'b0;
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            armed = 1'b0;
        end else begin
            nxt_start   = start;
            nxt_psel    = psel;
            nxt_penable = penable;
            if (start && !busy) begin
                picks_due = {picks_due, serve_pick(i_random_value)};
                void'(cmd_q.pop_front());
                armed     = 1'b0;
                nxt_start = 1'b0;
            end
            if (psel && penable && pwrite && pready) begin
                bag_cfg = pwdata[CNT_CFG_W-1:0];
                void'(cmd_q.pop_front());
                armed       = 1'b0;
                nxt_psel    = 1'b0;
                nxt_penable = 1'b0;
            end else if (psel && !penable) begin
                nxt_penable = 1'b1;
            end
            idle = picks_due.size() == 0 && !o_strobe && !busy && !start;
            if (!nxt_start && !nxt_psel && cmd_q.size() != 0) begin
                head = cmd_q[0];
                if (!armed) begin
                    gap_left = head.gap;
                    armed    = 1'b1;
                end
                case (head.op)
                    OP_PICK: begin
                        if (gap_left == 0) begin
                            nxt_start = 1'b1;
                            i_random_value <= head.value[RND_W-1:0];
                        end else if (!head.after_busy || !busy) begin
                            gap_left--;
                        end
                    end
                    OP_WRITE: begin
                        if (idle) begin
                            nxt_psel = 1'b1;
                            pwrite <= 1'b1;
                            paddr  <= ENTRY_COUNT_ADDR;
                            pwdata <= head.value;
                        end
                    end
                    OP_DRAIN: begin
                        if (idle) begin
                            void'(cmd_q.pop_front());
                            armed = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            start   <= nxt_start;
            psel    <= nxt_psel;
            penable <= nxt_penable;
        end
    end

    always @(posedge i_clk) begin : watch_p
        t_pick want;
        if (i_rst_n && o_strobe) begin
            if (picks_due.size() == 0) begin
                log_mismatch("unexpected result", int'(o_picked_index), -1);
            end else begin
                want = picks_due.pop_front();
                if (o_picked_index !== want.idx)
                    log_mismatch("picked_index", int'(o_picked_index), int'(want.idx));
                if (o_empty_error !== want.err)
                    log_mismatch("empty_error", int'(o_empty_error), int'(want.err));
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin : watchdog_p
        if (!i_rst_n || (start && !busy) || o_strobe || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stim_p
        int sel;
        int cnt;
        int reps;
        // empty bag straight after reset
        add_pick(16'h0000);
        add_pick(16'hFFFF);
        // two entries: cycle ends holding index 0
        add_write(2);
        add_pick(16'h0001);
        add_pick(16'hFFFF);
        // shrink to one while 0 is held: refill comes up empty
        add_write(1);
        add_pick(16'h1234);
        add_pick(16'h0000);
        // finish a cycle of five, then shrink below the held index
        add_write(5);
        repeat (5) add_pick(16'h0000);
        add_write(2);
        add_pick(16'h0000);
        add_pick(16'hFFFF);
        add_pick(16'h0003);
        add_write(BAG_MAX);
        add_pick(16'hFFFF);
        add_pick(16'h8000);
        add_pick(16'h0001);
        add_pick(16'h5555);
        add_pick(16'hAAAA);
        // oversized count clamps to the list depth
        add_write(127);
        add_pick(16'h7FFF);
        add_pick(16'hFFFE);

        while (picks_queued < PICK_TARGET) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) cnt = 0;
            else if (sel == 1) cnt = $urandom_range(BAG_MAX + 1, 127);
            else if (sel <= 4) cnt = $urandom_range(17, BAG_MAX);
            else cnt = $urandom_range(1, 16);
            add_write(cnt);
            calm = ($urandom_range(0, 3) == 0);
            reps = $urandom_range(1, ((cnt > BAG_MAX) ? BAG_MAX : cnt) * 2 + 2);
            if (reps > 48) reps = $urandom_range(16, 48);
            for (int k = 0; k < reps; k++) begin
                add_pick(RND_W'($urandom_range(0, 16'hFFFF)));
                if ($urandom_range(0, 29) == 0) add_drain();
            end
        end
        add_drain();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cmd_q.size() != 0 || start || psel) @(posedge i_clk);
        while (picks_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/sbip_pkg.sv
hdl/sbip_mod.sv
hdl/sbip_dp.sv
hdl/sbip_ctrl.sv
hdl/shuffle_bag_index_picker.sv
tb/sv/shuffle_bag_index_picker_tb.sv
